// ===== hw/rtl/uld_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 line decoder.
// Used by the front end, the event queue, the back end and the top level.
package uld_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_BREAK = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_LEAD  = 2'd1,
    ERR_CONT  = 2'd2,
    ERR_TRUNC = 2'd3
  } err_e;

  typedef enum logic {
    ACT_DATA = 1'b0,
    ACT_END  = 1'b1
  } action_e;

  localparam logic [15:0] CP_BOM = 16'hFEFF;
  localparam logic [15:0] CP_CR  = 16'h000D;
  localparam logic [15:0] CP_LF  = 16'h000A;

  localparam logic [7:0] MASK_2B_LEAD = 8'hE0;
  localparam logic [7:0] CODE_2B_LEAD = 8'hC0;
  localparam logic [7:0] MASK_3B_LEAD = 8'hF0;
  localparam logic [7:0] CODE_3B_LEAD = 8'hE0;
  localparam logic [7:0] MASK_CONT    = 8'hC0;
  localparam logic [7:0] CODE_CONT    = 8'h80;

  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_TWO  = 2'd2;
  localparam logic [1:0] SEQ_THREE = 2'd3;

  // One classified request: an optional first result, then an optional done marker.
  typedef struct packed {
    logic        has_res;
    kind_e       kind;
    logic [15:0] code_point;
    err_e        error_code;
    logic        has_done;
  } evt_t;

endpackage

// ===== hw/rtl/uld_front.sv =====
`timescale 1ns / 1ps
// Front end: takes one request per cycle while accept_i is high, decodes UTF-8 and line state, emits events.
// Depends on uld_pkg.
module uld_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          action_i,
  input  logic [7:0]    data_byte_i,
  output logic          push_o,
  output uld_pkg::evt_t evt_o
);
  import uld_pkg::*;

  logic [1:0]  seq_length_q, seq_length_d;
  logic [1:0]  bytes_taken_q, bytes_taken_d;
  logic [15:0] code_accum_q, code_accum_d;
  logic        prev_was_cr_q, prev_was_cr_d;
  logic        line_nonempty_q, line_nonempty_d;
  logic        at_start_q, at_start_d;
  logic        error_seen_q, error_seen_d;

  logic        char_done;
  logic [15:0] char_word;
  logic [1:0]  taken_inc;
  logic [15:0] accum_or;
  evt_t        evt;

  assign taken_inc = bytes_taken_q + 2'd1;
  assign accum_or  = (seq_length_q == SEQ_THREE && bytes_taken_q == 2'd1)
                   ? (code_accum_q | {4'd0, data_byte_i[5:0], 6'd0})
                   : (code_accum_q | {10'd0, data_byte_i[5:0]});

  always_comb begin
    seq_length_d    = seq_length_q;
    bytes_taken_d   = bytes_taken_q;
    code_accum_d    = code_accum_q;
    prev_was_cr_d   = prev_was_cr_q;
    line_nonempty_d = line_nonempty_q;
    at_start_d      = at_start_q;
    error_seen_d    = error_seen_q;
    char_done       = 1'b0;
    char_word       = 16'd0;
    evt             = '0;
    evt.kind        = KIND_CHAR;
    evt.error_code  = ERR_NONE;

    if (action_i == ACT_END) begin
      if (!error_seen_q) begin
        if (seq_length_q != SEQ_NONE) begin
          evt.has_res    = 1'b1;
          evt.kind       = KIND_ERROR;
          evt.error_code = ERR_TRUNC;
        end else if (line_nonempty_q) begin
          evt.has_res = 1'b1;
          evt.kind    = KIND_BREAK;
        end
      end
      evt.has_done    = 1'b1;
      seq_length_d    = SEQ_NONE;
      bytes_taken_d   = 2'd0;
      code_accum_d    = 16'd0;
      prev_was_cr_d   = 1'b0;
      line_nonempty_d = 1'b0;
      at_start_d      = 1'b1;
      error_seen_d    = 1'b0;
    end else if (!error_seen_q) begin
      if (seq_length_q == SEQ_NONE) begin
        if (!data_byte_i[7]) begin
          char_done = 1'b1;
          char_word = {8'd0, data_byte_i};
        end else if ((data_byte_i & MASK_2B_LEAD) == CODE_2B_LEAD) begin
          seq_length_d  = SEQ_TWO;
          bytes_taken_d = 2'd1;
          code_accum_d  = {5'd0, data_byte_i[4:0], 6'd0};
        end else if ((data_byte_i & MASK_3B_LEAD) == CODE_3B_LEAD) begin
          seq_length_d  = SEQ_THREE;
          bytes_taken_d = 2'd1;
          code_accum_d  = {data_byte_i[3:0], 12'd0};
        end else begin
          error_seen_d   = 1'b1;
          evt.has_res    = 1'b1;
          evt.kind       = KIND_ERROR;
          evt.error_code = ERR_LEAD;
        end
      end else if ((data_byte_i & MASK_CONT) != CODE_CONT) begin
        error_seen_d   = 1'b1;
        seq_length_d   = SEQ_NONE;
        bytes_taken_d  = 2'd0;
        code_accum_d   = 16'd0;
        evt.has_res    = 1'b1;
        evt.kind       = KIND_ERROR;
        evt.error_code = ERR_CONT;
      end else if (taken_inc >= seq_length_q) begin
        seq_length_d  = SEQ_NONE;
        bytes_taken_d = 2'd0;
        code_accum_d  = 16'd0;
        char_done     = 1'b1;
        char_word     = accum_or;
      end else begin
        bytes_taken_d = taken_inc;
        code_accum_d  = accum_or;
      end
    end

    // Classify a completed character
    if (char_done) begin
      at_start_d = 1'b0;
      if (at_start_q && char_word == CP_BOM) begin
        // drop the byte-order mark
      end else if (char_word == CP_LF && prev_was_cr_q) begin
        prev_was_cr_d = 1'b0;
      end else if (char_word == CP_CR || char_word == CP_LF) begin
        prev_was_cr_d   = (char_word == CP_CR);
        line_nonempty_d = 1'b0;
        evt.has_res     = 1'b1;
        evt.kind        = KIND_BREAK;
      end else begin
        prev_was_cr_d   = 1'b0;
        line_nonempty_d = 1'b1;
        evt.has_res     = 1'b1;
        evt.kind        = KIND_CHAR;
        evt.code_point  = char_word;
      end
    end
  end

  assign evt_o  = evt;
  assign push_o = accept_i && (evt.has_res || evt.has_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_length_q    <= SEQ_NONE;
      bytes_taken_q   <= 2'd0;
      code_accum_q    <= 16'd0;
      prev_was_cr_q   <= 1'b0;
      line_nonempty_q <= 1'b0;
      at_start_q      <= 1'b1;
      error_seen_q    <= 1'b0;
    end else if (accept_i) begin
      seq_length_q    <= seq_length_d;
      bytes_taken_q   <= bytes_taken_d;
      code_accum_q    <= code_accum_d;
      prev_was_cr_q   <= prev_was_cr_d;
      line_nonempty_q <= line_nonempty_d;
      at_start_q      <= at_start_d;
      error_seen_q    <= error_seen_d;
    end
  end

endmodule

// ===== hw/rtl/uld_queue.sv =====
`timescale 1ns / 1ps
// Short event queue between the front and back ends.
// Depends on uld_pkg for the event type.
module uld_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uld_pkg::evt_t push_data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          nonempty_o,
  output uld_pkg::evt_t head_o
);
  import uld_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  evt_t            slots_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == CntFull);
  assign nonempty_o = (count_q != '0);
  assign head_o     = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/uld_back.sv =====
`timescale 1ns / 1ps
// Back end: expands queued events into results and holds them in the output register.
// Depends on uld_pkg.
module uld_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  uld_pkg::evt_t head_i,
  output logic          pop_o,
  output logic          valid_o,
  input  logic          stall_i,
  output logic [1:0]    kind_o,
  output logic [15:0]   code_point_o,
  output logic [1:0]    error_code_o,
  output logic          last_o
);
  import uld_pkg::*;

  logic        phase_q;
  logic        out_valid_q;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] cp_q, cp_d;
  logic [1:0]  err_q, err_d;
  logic        last_q, last_d;
  logic        load;
  logic        use_first;

  assign use_first = head_i.has_res && !phase_q;
  assign load      = head_valid_i && (!out_valid_q || !stall_i);
  assign pop_o     = load && last_d;

  always_comb begin
    if (use_first) begin
      kind_d = head_i.kind;
      cp_d   = head_i.code_point;
      err_d  = head_i.error_code;
      last_d = !head_i.has_done;
    end else begin
      kind_d = KIND_DONE;
      cp_d   = 16'd0;
      err_d  = ERR_NONE;
      last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        phase_q     <= !last_d;
        out_valid_q <= 1'b1;
      end else if (!stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      cp_q   <= cp_d;
      err_q  <= err_d;
      last_q <= last_d;
    end
  end

  assign valid_o      = out_valid_q;
  assign kind_o       = kind_q;
  assign code_point_o = cp_q;
  assign error_code_o = err_q;
  assign last_o       = last_q;

endmodule

// ===== hw/rtl/utf8_line_decoder.sv =====
`timescale 1ns / 1ps
// UTF-8 line decoder top level: front end, event queue, back end.
// A result passes from the event queue into the output register, which drives valid_o.
// Throughput: one byte per cycle while stall_o is low; an end request giving a line break or
// truncation error plus done marker yields two results through the single output register.
// Reset clears decode state, queue and output register at once; no clearing pass.
module utf8_line_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] code_point_o,
  output logic [1:0]  error_code_o,
  output logic        last_o
);
  import uld_pkg::*;

  logic accept;
  logic push;
  logic pop;
  logic full;
  logic nonempty;
  evt_t push_evt;
  evt_t head_evt;

  assign stall_o = full;
  assign accept  = valid_i && !full;

  uld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .evt_o       (push_evt)
  );

  uld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_evt),
    .pop_i       (pop),
    .full_o      (full),
    .nonempty_o  (nonempty),
    .head_o      (head_evt)
  );

  uld_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (nonempty),
    .head_i       (head_evt),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .kind_o       (kind_o),
    .code_point_o (code_point_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

endmodule

// ===== dv/utf8_line_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf8_line_decoder: directed then random byte streams,
// random idling on both sides, results checked against an in-bench decoder.
// Depends on uld_pkg and the utf8_line_decoder top level.
module utf8_line_decoder_tb;
  import uld_pkg::*;

  localparam int RANDOM_REQS    = 2000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 90;
  localparam int HOLD_AFTER     = 400;

  typedef struct packed {
    logic       act;
    logic [7:0] data;
  } byte_req_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] code_point;
    err_e        error_code;
    logic        last;
  } dec_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        action_i = ACT_DATA;
  logic [7:0]  data_byte_i = 8'h00;
  logic        stall_i = 1'b0;
  logic        stall_o;
  logic        valid_o;
  logic [1:0]  kind_o;
  logic [15:0] code_point_o;
  logic [1:0]  error_code_o;
  logic        last_o;

  byte_req_t byte_req_q[$];
  dec_res_t  decoded_q[$];
  dec_res_t  step_res[$];
  dec_res_t  want;

  // decoder state
  logic [1:0]  open_len = SEQ_NONE;
  logic [1:0]  got_cnt = 2'd0;
  logic [15:0] partial_cp = 16'h0000;
  logic        after_cr = 1'b0;
  logic        line_has_text = 1'b0;
  logic        stream_fresh = 1'b1;
  logic        stream_failed = 1'b0;

  int   fail_cnt = 0;
  int   sent_cnt = 0;
  int   results_seen = 0;
  int   tail_start = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  logic offering = 1'b0;
  logic gaps_on = 1'b0;
  logic hold_done = 1'b0;
  logic timed_out = 1'b0;

  utf8_line_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .kind_o       (kind_o),
    .code_point_o (code_point_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void clear_decoder();
    open_len      = SEQ_NONE;
    got_cnt       = 2'd0;
    partial_cp    = 16'h0000;
    after_cr      = 1'b0;
    line_has_text = 1'b0;
    stream_fresh  = 1'b1;
    stream_failed = 1'b0;
  endfunction

  function automatic void add_res(kind_e kind, logic [15:0] cp, err_e err);
    dec_res_t res;
    res = '{kind: kind, code_point: cp, error_code: err, last: 1'b0};
    step_res.insert(step_res.size(), res);
  endfunction

  function automatic void complete_char(logic [15:0] w);
    logic was_fresh;
    was_fresh    = stream_fresh;
    stream_fresh = 1'b0;
    // drop a byte-order mark at the head of the stream
    if (was_fresh && w == CP_BOM) return;
    if (w == CP_LF && after_cr) begin
      after_cr = 1'b0;
      return;
    end
    if (w == CP_CR || w == CP_LF) begin
      after_cr      = (w == CP_CR);
      line_has_text = 1'b0;
      add_res(KIND_BREAK, 16'h0000, ERR_NONE);
      return;
    end
    after_cr      = 1'b0;
    line_has_text = 1'b1;
    add_res(KIND_CHAR, w, ERR_NONE);
  endfunction

  function automatic void fail_decode(err_e err);
    stream_failed = 1'b1;
    open_len      = SEQ_NONE;
    got_cnt       = 2'd0;
    partial_cp    = 16'h0000;
    add_res(KIND_ERROR, 16'h0000, err);
  endfunction

  function automatic void decode_request(logic act, logic [7:0] b);
    logic [15:0] w;
    step_res.delete();
    if (act == ACT_END) begin
      if (!stream_failed) begin
        if (open_len != SEQ_NONE) add_res(KIND_ERROR, 16'h0000, ERR_TRUNC);
        else if (line_has_text) add_res(KIND_BREAK, 16'h0000, ERR_NONE);
      end
      add_res(KIND_DONE, 16'h0000, ERR_NONE);
      clear_decoder();
    end else if (!stream_failed) begin
      if (open_len == SEQ_NONE) begin
        if (b < 8'h80) begin
          complete_char({8'h00, b});
        end else if ((b & MASK_2B_LEAD) == CODE_2B_LEAD) begin
          open_len   = SEQ_TWO;
          got_cnt    = 2'd1;
          partial_cp = {5'b0, b[4:0], 6'b0};
        end else if ((b & MASK_3B_LEAD) == CODE_3B_LEAD) begin
          open_len   = SEQ_THREE;
          got_cnt    = 2'd1;
          partial_cp = {b[3:0], 12'b0};
        end else begin
          fail_decode(ERR_LEAD);
        end
      end else if ((b & MASK_CONT) != CODE_CONT) begin
        fail_decode(ERR_CONT);
      end else begin
        if (open_len == SEQ_THREE && got_cnt == 2'd1) partial_cp = partial_cp | {4'b0, b[5:0], 6'b0};
        else partial_cp = partial_cp | {10'b0, b[5:0]};
        got_cnt = got_cnt + 2'd1;
        if (got_cnt >= open_len) begin
          w          = partial_cp;
          open_len   = SEQ_NONE;
          got_cnt    = 2'd0;
          partial_cp = 16'h0000;
          complete_char(w);
        end
      end
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) decoded_q.insert(decoded_q.size(), step_res[i]);
  endfunction

  function automatic void push_req(logic act, logic [7:0] data);
    byte_req_t req;
    req = '{act: act, data: data};
    byte_req_q.insert(byte_req_q.size(), req);
  endfunction

  // Encode in the given number of bytes; more bytes than needed gives an overlong form.
  function automatic void push_cp(logic [15:0] cp, int unsigned nbytes);
    case (nbytes)
      1: push_req(ACT_DATA, {1'b0, cp[6:0]});
      2: begin
        push_req(ACT_DATA, {3'b110, cp[10:6]});
        push_req(ACT_DATA, {2'b10, cp[5:0]});
      end
      default: begin
        push_req(ACT_DATA, {4'b1110, cp[15:12]});
        push_req(ACT_DATA, {2'b10, cp[11:6]});
        push_req(ACT_DATA, {2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void push_random_char(logic dirty);
    int unsigned r;
    logic [15:0] cp;
    r  = $urandom_range(0, 99);
    cp = 16'($urandom);
    if (dirty && r < 10) begin
      if (r < 5) begin
        push_req(ACT_DATA, cp[7:0]);
      end else if (r < 7) begin
        // open a sequence and cut it short
        push_req(ACT_DATA, {3'b110, cp[4:0]});
      end else begin
        push_req(ACT_DATA, {4'b1110, cp[3:0]});
        if (r == 9) push_req(ACT_DATA, {2'b10, cp[9:4]});
      end
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 40) push_cp(16'($urandom_range(16'h20, 16'h7E)), 1);
    else if (r < 48) push_cp(CP_CR, 1);
    else if (r < 54) push_cp(CP_LF, 1);
    else if (r < 58) begin
      push_cp(CP_CR, 1);
      push_cp(CP_LF, 1);
    end
    else if (r < 70) push_cp(16'($urandom_range(16'h80, 16'h7FF)), 2);
    else if (r < 84) push_cp(16'($urandom_range(16'h800, 16'hFFFF)), 3);
    else if (r < 87) push_cp(CP_BOM, 3);
    else if (r < 92) push_cp(16'($urandom_range(0, 16'h7F)), $urandom_range(2, 3));
    else push_cp(16'($urandom_range(0, 16'h7F)), 1);
  endfunction

  function automatic void push_stream();
    int unsigned n_chars;
    logic dirty;
    dirty   = ($urandom_range(0, 9) < 3);
    n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) push_cp(CP_BOM, 3);
    repeat (n_chars) push_random_char(dirty);
    push_req(ACT_END, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
      fail_cnt++;
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i     <= 1'b0;
      action_i    <= ACT_DATA;
      data_byte_i <= 8'h00;
      gap_left    = 0;
      clear_decoder();
    end else begin
      offering = valid_i;
      if (valid_i && !stall_o) begin
        decode_request(action_i, data_byte_i);
        byte_req_q.delete(0);
        sent_cnt++;
        offering = 1'b0;
        if (gaps_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 13);
      end
      gaps_on <= (sent_cnt < tail_start) && ((sent_cnt / 150) % 4 != 3);
      // hold a stalled request as it is
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
          valid_i <= 1'b0;
        end else if (byte_req_q.size() == 0) begin
          valid_i <= 1'b0;
        end else begin
          valid_i     <= 1'b1;
          action_i    <= byte_req_q[0].act;
          data_byte_i <= byte_req_q[0].data;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i    <= 1'b0;
      stall_left = 0;
    end else begin
      if (valid_o && !stall_i) begin
        results_seen++;
        if (decoded_q.size() == 0) begin
          $display("%0t: result with none expected: kind %0d, code point %h, error %0d, last %0b",
                   $time, kind_o, code_point_o, error_code_o, last_o);
          fail_cnt++;
        end else begin
          want = decoded_q[0];
          decoded_q.delete(0);
          check_field("kind", 16'(want.kind), 16'(kind_o));
          check_field("code_point", want.code_point, code_point_o);
          check_field("error_code", 16'(want.error_code), 16'(error_code_o));
          check_field("last", 16'(want.last), 16'(last_o));
        end
      end
      // one long hold so the block backs up into its input
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        stall_left--;
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  initial begin
    // byte-order mark, character, CR-LF, bare LF, two- and three-byte forms
    push_req(ACT_DATA, 8'hEF); push_req(ACT_DATA, 8'hBB); push_req(ACT_DATA, 8'hBF);
    push_req(ACT_DATA, 8'h00); push_req(ACT_DATA, 8'h0D); push_req(ACT_DATA, 8'h0A);
    push_req(ACT_DATA, 8'h0A); push_req(ACT_DATA, 8'hC3); push_req(ACT_DATA, 8'hA9);
    push_req(ACT_DATA, 8'hE2); push_req(ACT_DATA, 8'h82); push_req(ACT_DATA, 8'hAC);
    push_req(ACT_END, 8'hFF);
    push_req(ACT_END, 8'h00);
    // stray continuation as lead, then a byte that is ignored
    push_req(ACT_DATA, 8'h80); push_req(ACT_DATA, 8'h41); push_req(ACT_END, 8'h00);
    push_req(ACT_DATA, 8'hC2); push_req(ACT_DATA, 8'h41); push_req(ACT_END, 8'h00);
    push_req(ACT_DATA, 8'hE4); push_req(ACT_DATA, 8'h80); push_req(ACT_END, 8'h00);
    // overlong CR, then an invalid lead byte
    push_req(ACT_DATA, 8'hC0); push_req(ACT_DATA, 8'h8D); push_req(ACT_DATA, 8'hFF);
    push_req(ACT_END, 8'h00);
    while (byte_req_q.size() < RANDOM_REQS + 27) push_stream();
    tail_start = byte_req_q.size() * 85 / 100;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (!timed_out && !(byte_req_q.size() == 0 && decoded_q.size() == 0)) begin
      @(posedge clk_i);
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end
    if (timed_out) $display("%0t: watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    else repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (!timed_out && fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
